[hw/rtl/vlqpd_pkg.sv]
// Shared types and constants for the VLQ pair decoder.
`timescale 1ns / 1ps
package vlqpd_pkg;

  // Result word field widths (fixed by the port list)
  localparam int unsigned OutValW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BytesW  = 4;
  localparam int unsigned GroupW  = 7;

  // Queue depths
  localparam int unsigned FrontDepth = 2;
  localparam int unsigned ResDepth   = 2;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [StatusW-1:0] STATUS_TRUNC    = 2'd2;

  // Classified input byte
  typedef struct packed {
    logic              cont;
    logic              last;
    logic [GroupW-1:0] grp;
  } byte_info_t;

  // One result word
  typedef struct packed {
    logic [OutValW-1:0] first_value;
    logic [OutValW-1:0] second_value;
    logic [StatusW-1:0] status;
    logic [BytesW-1:0]  bytes_used;
  } result_t;

endpackage

[hw/rtl/vlq_pair_decoder_unit.sv]
// Top level of the VLQ pair decoder: front queue, decoder, result queue.
// Order: a pushed word is registered in the front queue, then decoded; its
//   result (if any) is registered in the result queue and shows with empty low.
// Throughput: one byte per cycle, bounded by the single-step accumulator
//   update in the decoder and by the consumer's pop rate.
// Reset: rst_ni (async, active low) empties both queues and returns the
//   decoder to the start of a pair with cleared accumulators; no sweep.
`timescale 1ns / 1ps
module vlq_pair_decoder_unit #(
  parameter int unsigned MAX_CONT_GROUP = 5,
  parameter int unsigned VALUE_WIDTH    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input byte queue side
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] first_value_o,
  output logic signed [31:0] second_value_o,
  output logic [1:0]         status_o,
  output logic [3:0]         bytes_used_o
);

  // Front queue -> decoder
  logic                  front_valid;
  vlqpd_pkg::byte_info_t front_info;
  logic                  back_pop;

  // Decoder -> result queue
  logic                  res_space;
  logic                  res_push;
  vlqpd_pkg::result_t    res_word;
  vlqpd_pkg::result_t    head_word;

  // The front classifies each byte (continuation, last flag, 7-bit group)
  // and holds up to two words; a push is refused while both are held, even
  // in a cycle in which the decoder pops one.
  vlqpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .valid_o     (front_valid),
    .info_o      (front_info),
    .pop_i       (back_pop)
  );

  // The decoder takes one word per cycle whenever a word is present and the
  // result queue can absorb a result, whether or not this word produces one.
  vlqpd_back #(
    .MAX_CONT_GROUP (MAX_CONT_GROUP),
    .VALUE_WIDTH    (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_info_i   (front_info),
    .in_pop_o    (back_pop),
    .res_space_i (res_space),
    .res_push_o  (res_push),
    .res_o       (res_word)
  );

  // Result words wait here until popped.
  vlqpd_result_fifo u_res (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_word),
    .space_o (res_space),
    .empty_o (empty),
    .data_o  (head_word),
    .pop_i   (pop)
  );

  assign first_value_o  = head_word.first_value;
  assign second_value_o = head_word.second_value;
  assign status_o       = head_word.status;
  assign bytes_used_o   = head_word.bytes_used;

  // The decoder only advances on a word that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> front_valid)
    else $error("decoder consumed from an empty front queue");

  // A result is only produced when the result queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> res_space)
    else $error("result pushed into a full result queue");

  // Error words carry zero values and a zero byte count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != vlqpd_pkg::STATUS_OK) |->
      (first_value_o == '0 && second_value_o == '0 && bytes_used_o == '0))
    else $error("error word with nonzero payload");

  // A success word counts at least the two final groups (checked for MAX_CONT_GROUP below 7).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_word.status == vlqpd_pkg::STATUS_OK &&
     MAX_CONT_GROUP < 7) |-> (res_word.bytes_used >= 4'd2))
    else $error("decoded pair with fewer than two bytes");

endmodule

[hw/rtl/vlqpd_front.sv]
// Front end: splits each byte into its fields and buffers it for the decoder.
`timescale 1ns / 1ps
module vlqpd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 valid_o,
  output vlqpd_pkg::byte_info_t info_o,
  input  logic                 pop_i
);

  localparam int unsigned PtrW = $clog2(vlqpd_pkg::FrontDepth);
  localparam int unsigned CntW = $clog2(vlqpd_pkg::FrontDepth + 1);

  vlqpd_pkg::byte_info_t mem_q [vlqpd_pkg::FrontDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;
  vlqpd_pkg::byte_info_t info_in;

  assign full_o  = (count_q == CntW'(vlqpd_pkg::FrontDepth));
  assign valid_o = (count_q != '0);
  assign info_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    info_in.cont = data_byte_i[7];
    info_in.last = last_byte_i;
    info_in.grp  = data_byte_i[6:0];
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(vlqpd_pkg::FrontDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(vlqpd_pkg::FrontDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= info_in;
    end
  end

endmodule

[hw/rtl/vlqpd_back.sv]
// Back end: accumulates groups, tracks the pair phase, and forms result words.
`timescale 1ns / 1ps
module vlqpd_back #(
  parameter int unsigned MAX_CONT_GROUP = 5,
  parameter int unsigned VALUE_WIDTH    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  vlqpd_pkg::byte_info_t in_info_i,
  output logic                  in_pop_o,
  input  logic                  res_space_i,
  output logic                  res_push_o,
  output vlqpd_pkg::result_t    res_o
);

  localparam int unsigned GcW    = $clog2(MAX_CONT_GROUP + 1);
  localparam int unsigned CntRaw = $clog2(2 * MAX_CONT_GROUP + 3);
  localparam int unsigned CntW   = (CntRaw < vlqpd_pkg::BytesW) ? vlqpd_pkg::BytesW : CntRaw;

  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  logic [1:0]             phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] first_q, first_d;
  logic [VALUE_WIDTH-1:0] second_q, second_d;
  logic [GcW-1:0]         gc_q, gc_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   step;
  logic                   in_second;
  logic [CntW-1:0]        cnt_inc;
  logic [VALUE_WIDTH-1:0] acc_cur, acc_new;
  logic [63:0]            first_ext, acc_ext;

  assign step      = in_valid_i && res_space_i;
  assign in_pop_o  = step;
  assign in_second = (phase_q == PH_SECOND);
  assign cnt_inc   = cnt_q + 1'b1;
  assign acc_cur   = in_second ? second_q : first_q;
  assign acc_new   = {acc_cur[VALUE_WIDTH-8:0], in_info_i.grp};
  assign first_ext = 64'(first_q);
  assign acc_ext   = 64'(acc_new);

  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    second_d   = second_q;
    gc_d       = gc_q;
    cnt_d      = cnt_q;
    res_push_o = 1'b0;
    res_o.first_value  = '0;
    res_o.second_value = '0;
    res_o.status       = vlqpd_pkg::STATUS_OK;
    res_o.bytes_used   = '0;

    if (phase_q == PH_DISCARD) begin
      if (in_info_i.last) begin
        phase_d  = PH_FIRST;
        first_d  = '0;
        second_d = '0;
        gc_d     = '0;
        cnt_d    = '0;
      end
    end else if (!in_info_i.cont) begin
      // final group of a value
      if (!in_second) begin
        if (in_info_i.last) begin
          phase_d      = PH_FIRST;
          first_d      = '0;
          second_d     = '0;
          gc_d         = '0;
          cnt_d        = '0;
          res_push_o   = 1'b1;
          res_o.status = vlqpd_pkg::STATUS_TRUNC;
        end else begin
          phase_d = PH_SECOND;
          first_d = acc_new;
          gc_d    = '0;
          cnt_d   = cnt_inc;
        end
      end else begin
        phase_d    = PH_FIRST;
        first_d    = '0;
        second_d   = '0;
        gc_d       = '0;
        cnt_d      = '0;
        res_push_o = 1'b1;
        res_o.first_value  = first_ext[vlqpd_pkg::OutValW-1:0];
        res_o.second_value = acc_ext[vlqpd_pkg::OutValW-1:0];
        res_o.status       = vlqpd_pkg::STATUS_OK;
        res_o.bytes_used   = cnt_inc[vlqpd_pkg::BytesW-1:0];
      end
    end else if (acc_new[VALUE_WIDTH-1] || (gc_q >= GcW'(MAX_CONT_GROUP))) begin
      // overflow wins over truncation; drop the rest of the buffer
      phase_d      = in_info_i.last ? PH_FIRST : PH_DISCARD;
      first_d      = '0;
      second_d     = '0;
      gc_d         = '0;
      cnt_d        = '0;
      res_push_o   = 1'b1;
      res_o.status = vlqpd_pkg::STATUS_OVERFLOW;
    end else if (in_info_i.last) begin
      phase_d      = PH_FIRST;
      first_d      = '0;
      second_d     = '0;
      gc_d         = '0;
      cnt_d        = '0;
      res_push_o   = 1'b1;
      res_o.status = vlqpd_pkg::STATUS_TRUNC;
    end else begin
      gc_d  = gc_q + 1'b1;
      cnt_d = cnt_inc;
      if (in_second) begin
        second_d = acc_new;
      end else begin
        phase_d = PH_FIRST;
        first_d = acc_new;
      end
    end

    if (!step) begin
      res_push_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
      gc_q     <= '0;
      cnt_q    <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      gc_q     <= gc_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[hw/rtl/vlqpd_result_fifo.sv]
// Result queue between the decoder and the consumer.
`timescale 1ns / 1ps
module vlqpd_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vlqpd_pkg::result_t data_i,
  output logic               space_o,
  output logic               empty_o,
  output vlqpd_pkg::result_t data_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = $clog2(vlqpd_pkg::ResDepth);
  localparam int unsigned CntW = $clog2(vlqpd_pkg::ResDepth + 1);

  vlqpd_pkg::result_t mem_q [vlqpd_pkg::ResDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop, is_full;

  assign is_full = (count_q == CntW'(vlqpd_pkg::ResDepth));
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  // a word leaving this cycle frees a slot for the one arriving
  assign space_o = !is_full || do_pop;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(vlqpd_pkg::ResDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(vlqpd_pkg::ResDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
